// File: hdl/ffsa_pkg.sv
// Shared constants, types and helpers for the first-fit segment allocator.
// Used by the cell row and the top level; no dependencies.
package ffsa_pkg;

	localparam int MaxSegments = 64;
	localparam int HeaderBytes = 16;
	localparam int AddressBits = 32;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOFIT   = 2'd1;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
	localparam logic [1:0] STATUS_FULL    = 2'd3;

	localparam logic OPCODE_ALLOC = 1'b0;
	localparam logic OPCODE_FREE  = 1'b1;

	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_BYTES = 1'b1;

	typedef enum logic [2:0] {
		CELL_NONE,
		CELL_INIT,
		CELL_MARK,
		CELL_SPLIT,
		CELL_MERGE
	} cell_op_t;

	// Broadcast command to every cell of the row
	typedef struct packed {
		cell_op_t    op;
		logic        flag;
		logic [31:0] size_a;
		logic [31:0] size_b;
	} cell_cmd_t;

	// Size of two neighbors joined, header of the second reclaimed, saturated
	function automatic logic [31:0] merged_size(input logic [31:0] a, input logic [31:0] b,
			input logic [6:0] hdr);
		logic [33:0] s;
		s = {2'b0, a} + {2'b0, b} + {27'b0, hdr};
		return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// File: hdl/ffsa_req_if.sv
// Request channel of the allocator: valid/ready plus the request beat.
// Depends on nothing.
interface ffsa_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] request_bytes;
	logic [31:0] block_address;

	modport source (output valid, output opcode, output request_bytes, output block_address,
		input ready);
	modport sink (input valid, input opcode, input request_bytes, input block_address,
		output ready);
endinterface

// File: hdl/ffsa_rsp_if.sv
// Response channel of the allocator: valid/ready plus the result beat.
// Depends on nothing.
interface ffsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_address;
	logic [1:0]  status;

	modport source (output valid, output data_address, output status, input ready);
	modport sink (input valid, input data_address, input status, output ready);
endinterface

// File: hdl/ffsa_cell.sv
// One segment cell of the allocator row: holds start, size, used and valid,
// compares against the broadcast request and shifts with its neighbors. Uses ffsa_pkg.
module ffsa_cell #(
	parameter int AB  = ffsa_pkg::AddressBits,
	parameter int IW  = 6,
	parameter int IDX = 0,
	parameter int HDR = ffsa_pkg::HeaderBytes
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ffsa_pkg::cell_cmd_t cmd,
	input  logic [IW-1:0]      pos,
	input  logic [AB-1:0]      wr_start,
	input  logic [31:0]        req_bytes,
	input  logic [31:0]        match_addr,
	input  logic [AB-1:0]      left_start,
	input  logic [31:0]        left_size,
	input  logic               left_used,
	input  logic               left_valid,
	input  logic [AB-1:0]      right_start,
	input  logic [31:0]        right_size,
	input  logic               right_used,
	input  logic               right_valid,
	output logic [AB-1:0]      start,
	output logic [31:0]        size,
	output logic               used,
	output logic               valid,
	output logic               fit,
	output logic               hit
);

	localparam logic [IW:0] MyIdx = (IW+1)'(IDX);

	logic [AB-1:0] start_q;
	logic [31:0]   size_q;
	logic          used_q;
	logic          valid_q;
	logic [IW:0]   pos_w;
	logic [IW:0]   pos_next;
	logic [AB-1:0] data_start;

	assign pos_w      = {1'b0, pos};
	assign pos_next   = pos_w + 1'b1;
	assign data_start = start_q + AB'(HDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				ffsa_pkg::CELL_INIT: begin
					used_q  <= 1'b0;
					valid_q <= (IDX == 0) ? cmd.flag : 1'b0;
				end
				ffsa_pkg::CELL_MARK: begin
					if (MyIdx == pos_w) used_q <= cmd.flag;
				end
				ffsa_pkg::CELL_SPLIT: begin
					if (MyIdx == pos_w) begin
						used_q <= 1'b1;
					end else if (MyIdx == pos_next) begin
						used_q  <= 1'b0;
						valid_q <= 1'b1;
					end else if (MyIdx > pos_next) begin
						used_q  <= left_used;
						valid_q <= left_valid;
					end
				end
				ffsa_pkg::CELL_MERGE: begin
					if (MyIdx > pos_w) begin
						used_q  <= right_used;
						valid_q <= right_valid;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ffsa_pkg::CELL_INIT: begin
				if (IDX == 0) begin
					start_q <= wr_start;
					size_q  <= cmd.size_a;
				end
			end
			ffsa_pkg::CELL_SPLIT: begin
				if (MyIdx == pos_w) begin
					size_q <= cmd.size_a;
				end else if (MyIdx == pos_next) begin
					start_q <= wr_start;
					size_q  <= cmd.size_b;
				end else if (MyIdx > pos_next) begin
					start_q <= left_start;
					size_q  <= left_size;
				end
			end
			ffsa_pkg::CELL_MERGE: begin
				if (MyIdx == pos_w) begin
					size_q <= cmd.size_a;
				end else if (MyIdx > pos_w) begin
					start_q <= right_start;
					size_q  <= right_size;
				end
			end
			default: ;
		endcase
	end

	assign start = start_q;
	assign size  = size_q;
	assign used  = used_q;
	assign valid = valid_q;
	assign fit   = valid_q && !used_q && (size_q > req_bytes);
	assign hit   = valid_q && (32'(data_start) == match_addr);

endmodule

// File: hdl/first_fit_segment_allocator.sv
// First-fit heap allocator with coalescing: sequencer, result register and cell row.
// Depends on ffsa_pkg, ffsa_req_if, ffsa_rsp_if and ffsa_cell.
//
// Usage:
//  - req channel carries one beat per operation: opcode 0 allocates request_bytes,
//    opcode 1 frees the segment whose user data starts at block_address.
//  - rsp channel returns one beat per request: data_address (allocations only)
//    and status (ok, no fitting segment, unknown free address, table full).
//  - Configuration: cfg_we with cfg_index 0 writes heap_base, 1 heap_bytes; a write
//    rebuilds the table in the same cycle as one free segment (none if bytes < header).
//  - Every cell compares the request at once; a priority pick takes the first hit
//    and the row then splits or merges by shifting its cells.
//  - From accept, an allocate or an unknown free passes compare, pick, update, load;
//    a free that hits passes compare, pick, update, left merge, right merge, load.
//    One item is in work at a time; the sequencer returns to idle before it accepts
//    the next request.
//  - A finished result sits in the output register; the next request is taken
//    meanwhile, and its result holds in the sequencer until the receiver drains.
//  - Reset leaves heap_base and heap_bytes at zero, so the table is empty.
module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegments,
	parameter int HEADER_BYTES = ffsa_pkg::HeaderBytes,
	parameter int ADDRESS_BITS = ffsa_pkg::AddressBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	ffsa_req_if.sink    req_ch,
	ffsa_rsp_if.source  rsp_ch
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int AB = ADDRESS_BITS;
	localparam logic [IW-1:0] LastIdx = IW'(MAX_SEGMENTS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CMP   = 3'd1;
	localparam logic [2:0] ST_PICK  = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_LEFT  = 3'd4;
	localparam logic [2:0] ST_RIGHT = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]  state_q;
	logic        opcode_q;
	logic [31:0] req_q;
	logic [31:0] addr_q;
	logic [31:0] base_q;
	logic [31:0] bytes_q;
	logic [MAX_SEGMENTS-1:0] cand_q;
	logic [IW-1:0] idx_q;
	logic          found_q;
	logic [31:0]   res_data_q;
	logic [1:0]    res_status_q;
	logic          rsp_valid_q;
	logic [31:0]   rsp_data_q;
	logic [1:0]    rsp_status_q;

	logic [AB-1:0] seg_start [MAX_SEGMENTS];
	logic [31:0]   seg_size  [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] seg_used;
	logic [MAX_SEGMENTS-1:0] seg_valid;
	logic [MAX_SEGMENTS-1:0] seg_fit;
	logic [MAX_SEGMENTS-1:0] seg_hit;

	ffsa_pkg::cell_cmd_t cmd;
	logic [IW-1:0] cmd_pos;
	logic [AB-1:0] cmd_start;

	logic [IW-1:0] pick_idx;
	logic          pick_found;
	logic [IW-1:0] prev_idx;
	logic [IW-1:0] next_idx;
	logic          has_prev;
	logic          has_next;
	logic [33:0]   split_need;
	logic          do_split;
	logic          cfg_hit;
	logic [31:0]   new_base;
	logic [31:0]   new_bytes;
	logic          load_rsp;

	assign prev_idx   = idx_q - 1'b1;
	assign next_idx   = idx_q + 1'b1;
	assign has_prev   = (idx_q != '0);
	assign has_next   = (idx_q != LastIdx) && seg_valid[next_idx];
	assign split_need = {2'b0, req_q} + 34'(HEADER_BYTES) + 34'd1;
	assign do_split   = {2'b0, seg_size[idx_q]} >= split_need;
	assign cfg_hit    = cfg_we;
	assign new_base   = (cfg_index == ffsa_pkg::CFG_HEAP_BASE) ? cfg_wdata : base_q;
	assign new_bytes  = (cfg_index == ffsa_pkg::CFG_HEAP_BYTES) ? cfg_wdata : bytes_q;

	// First candidate wins
	always_comb begin
		pick_idx   = '0;
		pick_found = 1'b0;
		for (int k = MAX_SEGMENTS - 1; k >= 0; k--) begin
			if (cand_q[k]) begin
				pick_idx   = IW'(k);
				pick_found = 1'b1;
			end
		end
	end

	// Row command for this cycle
	always_comb begin
		cmd.op     = ffsa_pkg::CELL_NONE;
		cmd.flag   = 1'b0;
		cmd.size_a = '0;
		cmd.size_b = '0;
		cmd_pos    = idx_q;
		cmd_start  = '0;
		if (cfg_hit) begin
			cmd.op     = ffsa_pkg::CELL_INIT;
			cmd.flag   = new_bytes >= 32'(HEADER_BYTES);
			cmd.size_a = new_bytes - 32'(HEADER_BYTES);
			cmd_start  = AB'(new_base);
		end else begin
			case (state_q)
				ST_EXEC: begin
					if (found_q) begin
						if (opcode_q == ffsa_pkg::OPCODE_FREE) begin
							cmd.op = ffsa_pkg::CELL_MARK;
						end else if (!do_split) begin
							cmd.op   = ffsa_pkg::CELL_MARK;
							cmd.flag = 1'b1;
						end else if (!seg_valid[MAX_SEGMENTS-1]) begin
							cmd.op     = ffsa_pkg::CELL_SPLIT;
							cmd.size_a = req_q;
							cmd.size_b = seg_size[idx_q] - req_q - 32'(HEADER_BYTES);
							cmd_start  = seg_start[idx_q] + AB'(HEADER_BYTES) + AB'(req_q);
						end
					end
				end
				ST_LEFT: begin
					if (has_prev && !seg_used[prev_idx]) begin
						cmd.op     = ffsa_pkg::CELL_MERGE;
						cmd_pos    = prev_idx;
						cmd.size_a = ffsa_pkg::merged_size(seg_size[prev_idx], seg_size[idx_q],
							7'(HEADER_BYTES));
					end
				end
				ST_RIGHT: begin
					if (has_next && !seg_used[next_idx]) begin
						cmd.op     = ffsa_pkg::CELL_MERGE;
						cmd.size_a = ffsa_pkg::merged_size(seg_size[idx_q], seg_size[next_idx],
							7'(HEADER_BYTES));
					end
				end
				default: ;
			endcase
		end
	end

	assign load_rsp = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			base_q      <= '0;
			bytes_q     <= '0;
		end else begin
			if (cfg_we) begin
				base_q  <= new_base;
				bytes_q <= new_bytes;
			end
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp_ch.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (req_ch.valid) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_PICK;
				ST_PICK: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (found_q && opcode_q == ffsa_pkg::OPCODE_FREE) state_q <= ST_LEFT;
					else state_q <= ST_DONE;
				end
				ST_LEFT:  state_q <= ST_RIGHT;
				ST_RIGHT: state_q <= ST_DONE;
				ST_DONE:  if (load_rsp) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_ch.valid) begin
			opcode_q <= req_ch.opcode;
			req_q    <= req_ch.request_bytes;
			addr_q   <= 32'(AB'(req_ch.block_address));
		end
		if (state_q == ST_CMP) cand_q <= (opcode_q == ffsa_pkg::OPCODE_FREE) ? seg_hit : seg_fit;
		if (state_q == ST_PICK) begin
			idx_q   <= pick_idx;
			found_q <= pick_found;
		end
		if (state_q == ST_LEFT && has_prev && !seg_used[prev_idx]) idx_q <= prev_idx;
		if (state_q == ST_EXEC) begin
			res_data_q   <= '0;
			res_status_q <= ffsa_pkg::STATUS_OK;
			if (opcode_q == ffsa_pkg::OPCODE_FREE) begin
				if (!found_q) res_status_q <= ffsa_pkg::STATUS_UNKNOWN;
			end else if (!found_q) begin
				res_status_q <= ffsa_pkg::STATUS_NOFIT;
			end else if (do_split && seg_valid[MAX_SEGMENTS-1]) begin
				res_status_q <= ffsa_pkg::STATUS_FULL;
			end else begin
				res_data_q <= 32'(seg_start[idx_q] + AB'(HEADER_BYTES));
			end
		end
		if (load_rsp) begin
			rsp_data_q   <= res_data_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign req_ch.ready        = (state_q == ST_IDLE);
	assign rsp_ch.valid        = rsp_valid_q;
	assign rsp_ch.data_address = rsp_data_q;
	assign rsp_ch.status       = rsp_status_q;

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		logic [AB-1:0] l_start, r_start;
		logic [31:0]   l_size, r_size;
		logic          l_used, r_used, l_valid, r_valid;
		if (g == 0) begin : g_first
			assign l_start = '0;
			assign l_size  = '0;
			assign l_used  = 1'b0;
			assign l_valid = 1'b0;
		end else begin : g_mid_l
			assign l_start = seg_start[g-1];
			assign l_size  = seg_size[g-1];
			assign l_used  = seg_used[g-1];
			assign l_valid = seg_valid[g-1];
		end
		if (g == MAX_SEGMENTS - 1) begin : g_last
			assign r_start = '0;
			assign r_size  = '0;
			assign r_used  = 1'b0;
			assign r_valid = 1'b0;
		end else begin : g_mid_r
			assign r_start = seg_start[g+1];
			assign r_size  = seg_size[g+1];
			assign r_used  = seg_used[g+1];
			assign r_valid = seg_valid[g+1];
		end
		ffsa_cell #(.AB(AB), .IW(IW), .IDX(g), .HDR(HEADER_BYTES)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .pos(cmd_pos), .wr_start(cmd_start),
			.req_bytes(req_q), .match_addr(addr_q),
			.left_start(l_start), .left_size(l_size), .left_used(l_used), .left_valid(l_valid),
			.right_start(r_start), .right_size(r_size), .right_used(r_used),
			.right_valid(r_valid),
			.start(seg_start[g]), .size(seg_size[g]), .used(seg_used[g]),
			.valid(seg_valid[g]), .fit(seg_fit[g]), .hit(seg_hit[g])
		);
	end

	a_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && found_q) |-> seg_valid[idx_q])
		else $error("picked segment is not in the table");

	a_split_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ffsa_pkg::CELL_SPLIT) |-> !seg_valid[MAX_SEGMENTS-1])
		else $error("split issued into a full table");

	a_merge_frees_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ffsa_pkg::CELL_MERGE) |=> !seg_valid[MAX_SEGMENTS-1])
		else $error("merge left the last cell occupied");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid[1] |-> seg_valid[0])
		else $error("table has a hole at the head");

endmodule
